[hdl/cmfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmfr_pkg: shared types and constants
// Word layouts, codes and control/status groups for the CAN frame reassembler.
// ----------------------------------------------------------------------------
package cmfr_pkg;

	localparam int MASK_W = 8;

	localparam logic [1:0] KIND_FRAME   = 2'd0;
	localparam logic [1:0] KIND_READ    = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;

	localparam logic [1:0] ROLE_SHORT = 2'd0;
	localparam logic [1:0] ROLE_START = 2'd1;
	localparam logic [1:0] ROLE_DATA  = 2'd2;
	localparam logic [1:0] ROLE_END   = 2'd3;

	localparam logic [1:0] RES_ACK   = 2'd0;
	localparam logic [1:0] RES_READY = 2'd1;
	localparam logic [1:0] RES_READ  = 2'd2;

	localparam logic [2:0] ACK_OK          = 3'd0;
	localparam logic [2:0] ACK_UNSUPPORTED = 3'd1;
	localparam logic [2:0] ACK_BUSY        = 3'd2;
	localparam logic [2:0] ACK_LONG_DATA   = 3'd3;
	localparam logic [2:0] ACK_LONG_END    = 3'd4;
	localparam logic [2:0] ACK_FRAME_CODE  = 3'd5;
	localparam logic [2:0] ACK_OVERFLOW    = 3'd6;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT_DATA,
		PH_WAIT_END,
		PH_BUSY
	} phase_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_WRITE,
		S_READ
	} ctl_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  channel;
		logic [7:0]  sender_addr;
		logic [7:0]  frame_code;
		logic        long_flag;
		logic [1:0]  frame_role;
		logic [3:0]  byte_count;
		logic [63:0] payload;
		logic [9:0]  read_index;
	} req_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [3:0]  out_channel;
		logic [7:0]  out_sender_addr;
		logic [7:0]  out_frame_code;
		logic [2:0]  ack_code;
		logic [10:0] message_length;
		logic [7:0]  read_byte;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic commit;
		logic wr_step;
		logic rd_commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_read;
		logic res_valid;
		logic wr_pending;
		logic wr_last;
		logic out_free;
	} dp_sts_t;

	function automatic logic [7:0] pl_byte(input logic [63:0] p, input logic [2:0] i);
		logic [2:0] j;
		j = 3'd7 - i;
		return p[{j, 3'b000} +: 8];
	endfunction

endpackage
`default_nettype wire

[hdl/cmfr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmfr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cmfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[hdl/cmfr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmfr_ctrl: sequencing controller
// Captures a word, evaluates it, then steps buffer writes or a buffer read.
// ----------------------------------------------------------------------------
module cmfr_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire cmfr_pkg::dp_sts_t  sts,
	output cmfr_pkg::ctl_cmd_t      cmd
);

	import cmfr_pkg::*;

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
				if (req_valid) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (sts.is_read) begin
					state_d = S_READ;
				end else if (!sts.res_valid || sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = sts.wr_pending ? S_WRITE : S_IDLE;
				end
			end
			S_WRITE: begin
				cmd.wr_step = 1'b1;
				if (sts.wr_last) begin
					state_d = S_IDLE;
				end
			end
			S_READ: begin
				if (sts.out_free) begin
					cmd.rd_commit = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[hdl/cmfr_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmfr_dp: reassembly datapath
// Per-channel protocol state, frame checks, message buffer and result register.
// ----------------------------------------------------------------------------
module cmfr_dp #(
	parameter int CHANNELS     = 8,
	parameter int BUFFER_BYTES = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmfr_pkg::req_t       req,
	input  wire logic                 cfg_we,
	input  wire logic [7:0]           cfg_wdata,
	input  wire cmfr_pkg::ctl_cmd_t   cmd,
	output cmfr_pkg::dp_sts_t         sts,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output cmfr_pkg::rsp_t            rsp
);

	import cmfr_pkg::*;

	localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int BW   = $clog2(BUFFER_BYTES);
	localparam int RLW  = $clog2(BUFFER_BYTES + 1);
	localparam int SW   = RLW + 1;
	localparam int CMPW = 17;
	localparam int AW   = CW + BW;
	localparam int NCH  = 2 ** CW;

	req_t             req_q;
	logic [MASK_W-1:0] mask_q;

	phase_t           ph_q   [CHANNELS];
	logic [15:0]      el_q   [CHANNELS];
	logic [7:0]       ef_q   [CHANNELS];
	logic [RLW-1:0]   rl_q   [CHANNELS];
	logic [7:0]       rf_q   [CHANNELS];
	logic [7:0]       snd_q  [CHANNELS];
	logic [7:0]       code_q [CHANNELS];

	logic [3:0]       wr_n_q, wr_k_q;
	logic [RLW-1:0]   wbase_q;
	logic             wfirst_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             in_range, has_handler, is_short, is_start, is_data, is_end;
	logic [CW-1:0]    ci;
	logic [3:0]       dlc, n;
	logic [7:0]       p0, p1, p2;
	phase_t           ph, eph, nx_ph;
	logic [15:0]      el, nx_el;
	logic [7:0]       ef, nx_ef, rf, nx_rf, snd, nx_snd, code, nx_code;
	logic [RLW-1:0]   rl, nx_rl;
	logic [SW-1:0]    sum;
	logic             clr, res, rd_in_range;
	logic [1:0]       r_kind;
	logic [2:0]       r_ack;
	logic [7:0]       r_snd, r_code;
	logic [10:0]      r_len;
	logic [3:0]       wn;
	logic [RLW-1:0]   wbase;
	logic             wfirst;
	logic [AW-1:0]    waddr, raddr;
	logic [7:0]       wdata, rdata;

	assign in_range    = 5'(req_q.channel) < 5'(CHANNELS);
	assign ci          = in_range ? req_q.channel[CW-1:0] : '0;
	assign has_handler = (req_q.channel < 4'(MASK_W)) && mask_q[req_q.channel[2:0]];
	assign dlc         = (req_q.byte_count > 4'd8) ? 4'd8 : req_q.byte_count;
	assign n           = (dlc == 4'd0) ? 4'd0 : dlc - 4'd1;
	assign p0          = pl_byte(req_q.payload, 3'd0);
	assign p1          = pl_byte(req_q.payload, 3'd1);
	assign p2          = pl_byte(req_q.payload, 3'd2);
	assign is_short    = !req_q.long_flag && (req_q.frame_role == ROLE_SHORT);
	assign is_start    = req_q.long_flag && (req_q.frame_role == ROLE_START);
	assign is_data     = req_q.long_flag && (req_q.frame_role == ROLE_DATA);
	assign is_end      = req_q.long_flag && (req_q.frame_role == ROLE_END);

	assign ph   = ph_q[ci];
	assign el   = el_q[ci];
	assign ef   = ef_q[ci];
	assign rl   = rl_q[ci];
	assign rf   = rf_q[ci];
	assign snd  = snd_q[ci];
	assign code = code_q[ci];
	assign sum  = SW'(rl) + SW'(n);
	assign rd_in_range = 17'(req_q.read_index) < 17'(BUFFER_BYTES);

	always_comb begin
		nx_ph   = ph;
		nx_el   = el;
		nx_ef   = ef;
		nx_rl   = rl;
		nx_rf   = rf;
		nx_snd  = snd;
		nx_code = code;
		eph     = ph;
		clr     = 1'b0;
		res     = 1'b0;
		r_kind  = RES_ACK;
		r_ack   = ACK_OK;
		r_snd   = snd;
		r_code  = code;
		r_len   = '0;
		wn      = '0;
		wbase   = '0;
		wfirst  = 1'b0;
		if (in_range) begin
			case (req_q.kind)
				KIND_RELEASE: begin
					if (ph == PH_BUSY) begin
						clr = 1'b1;
					end
				end
				KIND_FRAME: begin
					if (req_q.frame_code == 8'd0) begin
						res   = 1'b1;
						r_ack = ACK_FRAME_CODE;
						clr   = 1'b1;
					end else begin
						if ((ph == PH_WAIT_DATA || ph == PH_WAIT_END) && (is_short || is_start)) begin
							eph = PH_IDLE;
							clr = 1'b1;
						end
						case (eph)
							PH_IDLE: begin
								if (is_short) begin
									clr     = 1'b0;
									nx_el   = 16'(dlc);
									nx_ef   = 8'd1;
									nx_rl   = RLW'(dlc);
									nx_rf   = 8'd1;
									nx_snd  = req_q.sender_addr;
									nx_code = req_q.frame_code;
									wn      = dlc;
									res     = 1'b1;
									r_snd   = req_q.sender_addr;
									r_code  = req_q.frame_code;
									if (has_handler) begin
										nx_ph  = PH_BUSY;
										r_kind = RES_READY;
										r_len  = 11'(dlc);
									end else begin
										nx_ph = PH_IDLE;
										r_ack = ACK_UNSUPPORTED;
									end
								end else if (is_start && dlc == 4'd3) begin
									clr     = 1'b0;
									nx_el   = {p0, p1};
									nx_ef   = p2;
									nx_rl   = '0;
									nx_rf   = 8'd0;
									nx_snd  = req_q.sender_addr;
									nx_code = req_q.frame_code;
									nx_ph   = PH_WAIT_DATA;
								end
							end
							PH_WAIT_DATA: begin
								if (snd == req_q.sender_addr) begin
									if (!is_data || p0 != rf) begin
										res   = 1'b1;
										r_ack = ACK_LONG_DATA;
										clr   = 1'b1;
									end else if (sum > SW'(BUFFER_BYTES)) begin
										res   = 1'b1;
										r_ack = ACK_OVERFLOW;
										clr   = 1'b1;
									end else begin
										wn     = n;
										wbase  = rl;
										wfirst = 1'b1;
										nx_rl  = RLW'(sum);
										nx_rf  = rf + 8'd1;
										if (CMPW'(nx_rl) < CMPW'(el) && nx_rf < ef) begin
											nx_ph = PH_WAIT_DATA;
										end else if (CMPW'(nx_rl) == CMPW'(el) && nx_rf == ef) begin
											nx_ph = PH_WAIT_END;
										end else begin
											res   = 1'b1;
											r_ack = ACK_LONG_DATA;
											clr   = 1'b1;
										end
									end
								end
							end
							PH_WAIT_END: begin
								if (snd == req_q.sender_addr) begin
									res = 1'b1;
									if (!is_end) begin
										r_ack = ACK_LONG_END;
										clr   = 1'b1;
									end else if (has_handler) begin
										nx_ph  = PH_BUSY;
										r_kind = RES_READY;
										r_len  = 11'(rl);
									end else begin
										nx_ph = PH_IDLE;
										r_ack = ACK_UNSUPPORTED;
									end
								end
							end
							PH_BUSY: begin
								res   = 1'b1;
								r_ack = ACK_BUSY;
							end
							default: begin
								res = 1'b0;
							end
						endcase
					end
				end
				default: begin
					res = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				ph_q[i]   <= PH_IDLE;
				el_q[i]   <= '0;
				ef_q[i]   <= '0;
				rl_q[i]   <= '0;
				rf_q[i]   <= '0;
				snd_q[i]  <= '0;
				code_q[i] <= '0;
			end
		end else if (cmd.commit && in_range) begin
			if (clr) begin
				ph_q[ci]   <= PH_IDLE;
				el_q[ci]   <= '0;
				ef_q[ci]   <= '0;
				rl_q[ci]   <= '0;
				rf_q[ci]   <= '0;
				snd_q[ci]  <= '0;
				code_q[ci] <= '0;
			end else begin
				ph_q[ci]   <= nx_ph;
				el_q[ci]   <= nx_el;
				ef_q[ci]   <= nx_ef;
				rl_q[ci]   <= nx_rl;
				rf_q[ci]   <= nx_rf;
				snd_q[ci]  <= nx_snd;
				code_q[ci] <= nx_code;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_n_q <= '0;
			wr_k_q <= '0;
		end else if (cmd.commit) begin
			wr_n_q <= wn;
			wr_k_q <= '0;
		end else if (cmd.wr_step) begin
			wr_k_q <= wr_k_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			wbase_q  <= wbase;
			wfirst_q <= wfirst;
		end
	end

	assign waddr = {ci, BW'(wbase_q) + BW'(wr_k_q)};
	assign wdata = pl_byte(req_q.payload, 3'(wr_k_q) + 3'(wfirst_q));
	assign raddr = {ci, BW'(req_q.read_index)};

	cmfr_ram #(
		.WIDTH(8),
		.DEPTH(NCH * (2 ** BW))
	) u_ram (
		.clk  (clk),
		.we   (cmd.wr_step),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((cmd.commit && res) || cmd.rd_commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && res) begin
			rsp_q.result_kind     <= r_kind;
			rsp_q.out_channel     <= req_q.channel;
			rsp_q.out_sender_addr <= r_snd;
			rsp_q.out_frame_code  <= r_code;
			rsp_q.ack_code        <= r_ack;
			rsp_q.message_length  <= r_len;
			rsp_q.read_byte       <= 8'd0;
		end else if (cmd.rd_commit) begin
			rsp_q.result_kind     <= RES_READ;
			rsp_q.out_channel     <= req_q.channel;
			rsp_q.out_sender_addr <= snd;
			rsp_q.out_frame_code  <= code;
			rsp_q.ack_code        <= ACK_OK;
			rsp_q.message_length  <= 11'(rl);
			rsp_q.read_byte       <= rd_in_range ? rdata : 8'd0;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign rsp            = rsp_q;
	assign sts.is_read    = in_range && (req_q.kind == KIND_READ);
	assign sts.res_valid  = res;
	assign sts.wr_pending = wn != 4'd0;
	assign sts.wr_last    = 4'(wr_k_q + 4'd1) == wr_n_q;
	assign sts.out_free   = !rsp_valid_q || rsp_ready;

endmodule
`default_nettype wire

[hdl/can_multichannel_frame_reassembler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_multichannel_frame_reassembler: CAN command frame reassembly
// Per-channel long/short message reassembly with acknowledge and ready reports.
// ----------------------------------------------------------------------------
//  channel   signals                      handshake
//  req       req_valid/req_ready/req      valid-ready, word taken on both high
//  rsp       rsp_valid/rsp_ready/rsp      valid-ready, registered output
//  cfg       cfg_we/cfg_wdata             write on cfg_we, no wait
//
// A word is captured and evaluated, then buffered bytes are written one per
// cycle, up to eight for a short frame; a read uses the buffer RAM read port.
// The single RAM write port sets the byte-per-cycle pace of frame storage.
// Reset clears all channel state; the message buffer is not cleared.
// A pending result stalls evaluation of the next result-producing word only.
// ----------------------------------------------------------------------------
module can_multichannel_frame_reassembler #(
	parameter int CHANNELS     = 8,
	parameter int BUFFER_BYTES = 1024
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire cmfr_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output cmfr_pkg::rsp_t       rsp,
	input  wire logic            cfg_we,
	input  wire logic [7:0]      cfg_wdata
);

	import cmfr_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	cmfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cmfr_dp #(
		.CHANNELS    (CHANNELS),
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire

[hdl/cmfr_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmfr_chk: port checker
// Result word consistency and output hold checks on the top-level ports.
// ----------------------------------------------------------------------------
module cmfr_chk (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            rsp_valid,
	input wire logic            rsp_ready,
	input wire cmfr_pkg::rsp_t  rsp
);

	import cmfr_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result word changed while stalled");

	a_rsp_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.result_kind == RES_ACK || rsp.result_kind == RES_READY ||
			rsp.result_kind == RES_READ))
		else $error("bad result kind");

	a_ack_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_kind == RES_ACK |->
			rsp.message_length == 11'd0 && rsp.read_byte == 8'd0 && rsp.ack_code != ACK_OK)
		else $error("acknowledge word carries data");

	a_nonack_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_kind != RES_ACK |-> rsp.ack_code == ACK_OK &&
			(rsp.result_kind == RES_READ || rsp.read_byte == 8'd0))
		else $error("ready or read word carries acknowledge code");

endmodule

bind can_multichannel_frame_reassembler cmfr_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: CAN frame reassembler testbench
// Sends frame, read and release words under random idling on both sides and
// checks every result word against a behavioural model of the channel logic.
// ----------------------------------------------------------------------------
module tb;
	import cmfr_pkg::*;

	localparam int NCH = 8;
	localparam int BUFB = 1024;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	can_multichannel_frame_reassembler #(.CHANNELS(NCH), .BUFFER_BYTES(BUFB)) DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// model state
	logic [7:0] m_mask;
	phase_t m_phase [NCH];
	logic [15:0] m_exp_len [NCH];
	logic [7:0] m_exp_frm [NCH];
	logic [15:0] m_rx_len [NCH];
	logic [7:0] m_rx_frm [NCH];
	logic [7:0] m_sender [NCH];
	logic [7:0] m_fcode [NCH];
	logic [7:0] m_store [NCH*BUFB];
	bit m_written [NCH*BUFB];

	rsp_t expected_rsp [$];
	int errors;
	int mismatches;
	int send_idle_pct;
	int recv_idle_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [7:0] byte_of(logic [63:0] p, int i);
		return p[56 - 8*(i & 7) +: 8];
	endfunction

	function automatic void clear_ch(int c);
		m_phase[c] = PH_IDLE;
		m_exp_len[c] = '0;
		m_exp_frm[c] = '0;
		m_rx_len[c] = '0;
		m_rx_frm[c] = '0;
		m_sender[c] = '0;
		m_fcode[c] = '0;
	endfunction

	function automatic void push_rsp(logic [1:0] rk, int c, logic [2:0] code,
			logic [15:0] len, logic [7:0] rb);
		rsp_t r;
		r.result_kind = rk;
		r.out_channel = c[3:0];
		r.out_sender_addr = m_sender[c];
		r.out_frame_code = m_fcode[c];
		r.ack_code = code;
		r.message_length = len[10:0];
		r.read_byte = rb;
		expected_rsp.push_back(r);
	endfunction

	function automatic void reject_frame(int c, logic [2:0] code);
		push_rsp(RES_ACK, c, code, 16'd0, 8'd0);
		clear_ch(c);
	endfunction

	function automatic void finish_message(int c);
		if (!m_mask[c]) begin
			m_phase[c] = PH_IDLE;
			push_rsp(RES_ACK, c, ACK_UNSUPPORTED, 16'd0, 8'd0);
		end else begin
			m_phase[c] = PH_BUSY;
			push_rsp(RES_READY, c, ACK_OK, m_rx_len[c], 8'd0);
		end
	endfunction

	function automatic void predict_word(req_t w);
		int c;
		int dlc;
		int n;
		bit sh, st, dt, en;
		logic [7:0] b;
		c = w.channel;
		dlc = (w.byte_count > 4'd8) ? 8 : int'(w.byte_count);
		if (c >= NCH) return;
		if (w.kind == KIND_READ) begin
			b = (w.read_index < BUFB) ? m_store[c*BUFB + w.read_index] : 8'd0;
			push_rsp(RES_READ, c, ACK_OK, m_rx_len[c], b);
			return;
		end
		if (w.kind == KIND_RELEASE) begin
			if (m_phase[c] == PH_BUSY) clear_ch(c);
			return;
		end
		if (w.kind != KIND_FRAME) return;
		if (w.frame_code == 8'd0) begin
			reject_frame(c, ACK_FRAME_CODE);
			return;
		end
		sh = !w.long_flag && w.frame_role == ROLE_SHORT;
		st = w.long_flag && w.frame_role == ROLE_START;
		dt = w.long_flag && w.frame_role == ROLE_DATA;
		en = w.long_flag && w.frame_role == ROLE_END;
		if ((m_phase[c] == PH_WAIT_DATA || m_phase[c] == PH_WAIT_END) && (sh || st))
			clear_ch(c);
		case (m_phase[c])
			PH_IDLE: begin
				if (sh) begin
					m_exp_len[c] = 16'(dlc);
					m_exp_frm[c] = 8'd1;
					m_rx_len[c] = 16'(dlc);
					m_rx_frm[c] = 8'd1;
					m_fcode[c] = w.frame_code;
					m_sender[c] = w.sender_addr;
					for (int i = 0; i < dlc; i++) begin
						m_store[c*BUFB + i] = byte_of(w.payload, i);
						m_written[c*BUFB + i] = 1'b1;
					end
					finish_message(c);
				end else if (st && dlc == 3) begin
					m_exp_len[c] = {byte_of(w.payload, 0), byte_of(w.payload, 1)};
					m_exp_frm[c] = byte_of(w.payload, 2);
					m_rx_len[c] = '0;
					m_rx_frm[c] = '0;
					m_fcode[c] = w.frame_code;
					m_sender[c] = w.sender_addr;
					m_phase[c] = PH_WAIT_DATA;
				end
			end
			PH_WAIT_DATA: begin
				if (m_sender[c] != w.sender_addr) return;
				if (!dt || byte_of(w.payload, 0) != m_rx_frm[c]) begin
					reject_frame(c, ACK_LONG_DATA);
					return;
				end
				n = (dlc > 0) ? dlc - 1 : 0;
				if (m_rx_len[c] + n > BUFB) begin
					reject_frame(c, ACK_OVERFLOW);
					return;
				end
				m_rx_frm[c] = m_rx_frm[c] + 8'd1;
				for (int i = 0; i < n; i++) begin
					m_store[c*BUFB + m_rx_len[c]] = byte_of(w.payload, i + 1);
					m_written[c*BUFB + m_rx_len[c]] = 1'b1;
					m_rx_len[c] = m_rx_len[c] + 16'd1;
				end
				if (m_rx_len[c] < m_exp_len[c] && m_rx_frm[c] < m_exp_frm[c]) return;
				if (m_rx_len[c] == m_exp_len[c] && m_rx_frm[c] == m_exp_frm[c]) begin
					m_phase[c] = PH_WAIT_END;
					return;
				end
				reject_frame(c, ACK_LONG_DATA);
			end
			PH_WAIT_END: begin
				if (m_sender[c] != w.sender_addr) return;
				if (!en) begin
					reject_frame(c, ACK_LONG_END);
					return;
				end
				finish_message(c);
			end
			default: push_rsp(RES_ACK, c, ACK_BUSY, 16'd0, 8'd0);
		endcase
	endfunction

	task automatic send_word(req_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		predict_word(w);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					errors++;
					if (mismatches++ < 10) $display("unexpected result %p", rsp);
				end else begin
					rsp_t e;
					e = expected_rsp.pop_front();
					if (e !== rsp) begin
						errors++;
						if (mismatches++ < 10) $display("mismatch exp %p got %p", e, rsp);
					end
				end
			end
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic drain();
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_mask(logic [7:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		m_mask = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic req_t mk_frame(int c, logic [7:0] snd, logic [7:0] fc,
			logic lf, logic [1:0] role, logic [3:0] dlc, logic [63:0] pl);
		req_t w;
		w = '0;
		w.kind = KIND_FRAME;
		w.channel = c[3:0];
		w.sender_addr = snd;
		w.frame_code = fc;
		w.long_flag = lf;
		w.frame_role = role;
		w.byte_count = dlc;
		w.payload = pl;
		w.read_index = 10'($urandom);
		return w;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_read(int c, int idx);
		req_t w;
		w = mk_frame(c, 8'($urandom), 8'($urandom), 1'($urandom), 2'($urandom),
			4'($urandom), rnd64());
		w.kind = KIND_READ;
		if (!m_written[c*BUFB + idx]) idx = 0;
		if (!m_written[c*BUFB + idx]) return;
		w.read_index = idx[9:0];
		send_word(w);
	endtask

	task automatic send_release(int c);
		req_t w;
		w = mk_frame(c, 8'($urandom), 8'($urandom), 1'($urandom), 2'($urandom),
			4'($urandom), rnd64());
		w.kind = KIND_RELEASE;
		send_word(w);
	endtask

	// long message with optional fault, total bytes and frames chosen by caller
	task automatic send_long(int c, logic [7:0] snd, int len, int frames, int fault);
		int left;
		int k;
		logic [63:0] pl;
		pl = rnd64();
		pl[63:40] = {len[15:0], frames[7:0]};
		send_word(mk_frame(c, snd, 8'($urandom_range(255, 1)), 1'b1, ROLE_START, 4'd3, pl));
		left = len;
		for (k = 0; k < frames; k++) begin
			int n;
			n = (k == frames - 1) ? left : ((left > 7) ? $urandom_range(7, 1) : left);
			if (n > 7) n = 7;
			if (frames - 1 - k > 0 && left - n < frames - 1 - k) n = 0;
			pl = rnd64();
			pl[63:56] = 8'((fault == 1 && k == frames / 2) ? k + 1 : k);
			if ($urandom_range(9) == 0)
				send_word(mk_frame(c, snd ^ 8'h5A, 8'h11, 1'b1, ROLE_DATA, 4'd8, rnd64()));
			send_word(mk_frame(c, snd, 8'($urandom_range(255, 1)), 1'b1, ROLE_DATA,
				(n == 7 && $urandom_range(1) != 0) ? 4'd15 : 4'(n + 1), pl));
			left -= n;
		end
		if (fault == 2)
			send_word(mk_frame(c, snd, 8'($urandom_range(255, 1)), 1'b1, ROLE_DATA, 4'd2,
				rnd64()));
		else if (fault != 3)
			send_word(mk_frame(c, snd, 8'($urandom_range(255, 1)), 1'b1, ROLE_END,
				4'($urandom), rnd64()));
	endtask

	task automatic test_directed();
		logic [63:0] pl;
		write_mask(8'h00);
		send_word(mk_frame(0, 8'hFF, 8'hFF, 1'b0, ROLE_SHORT, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
		send_word(mk_frame(1, 8'h00, 8'h01, 1'b0, ROLE_SHORT, 4'd15, 64'h0123_4567_89AB_CDEF));
		send_word(mk_frame(15, 8'h12, 8'h34, 1'b0, ROLE_SHORT, 4'd4, rnd64()));
		send_word(mk_frame(2, 8'h12, 8'h00, 1'b0, ROLE_SHORT, 4'd4, rnd64()));
		write_mask(8'hFF);
		send_word(mk_frame(3, 8'hA5, 8'h07, 1'b0, ROLE_SHORT, 4'd0, 64'h0));
		send_word(mk_frame(3, 8'hA5, 8'h08, 1'b0, ROLE_SHORT, 4'd2, rnd64()));
		send_read(0, 7);
		send_read(0, 1023);
		send_word(mk_frame(3, 8'hA5, 8'h00, 1'b0, ROLE_SHORT, 4'd2, rnd64()));
		send_release(3);
		send_release(4);
		send_word(mk_frame(4, 8'h21, 8'h09, 1'b1, ROLE_START, 4'd2, rnd64()));
		send_word(mk_frame(4, 8'h21, 8'h09, 1'b1, ROLE_END, 4'd2, rnd64()));
		send_word(mk_frame(4, 8'h21, 8'h09, 1'b0, ROLE_DATA, 4'd2, rnd64()));
		send_long(5, 8'h33, 10, 2, 0);
		send_read(5, 9);
		send_release(5);
		send_long(6, 8'h44, 10, 3, 1);
		send_long(6, 8'h44, 3, 2, 2);
		pl = 64'h0000_0000_0000_0000;
		send_word(mk_frame(7, 8'h55, 8'h10, 1'b1, ROLE_START, 4'd3, 64'h0002_0100_0000_0000));
		send_word(mk_frame(7, 8'h55, 8'h11, 1'b1, ROLE_DATA, 4'd0, pl));
		send_long(7, 8'h55, 1024, 147, 0);
		send_read(7, 1023);
		send_release(7);
		send_long(2, 8'h66, 1030, 148, 0);
	endtask

	task automatic test_random(int count);
		int c;
		for (int i = 0; i < count; i++) begin
			c = $urandom_range(NCH - 1);
			case ($urandom_range(9))
				0, 1, 2: send_long(c, 8'($urandom), $urandom_range(40),
					$urandom_range(6, 1), ($urandom_range(4) == 0) ? $urandom_range(3, 1) : 0);
				3, 4: send_word(mk_frame(c, 8'($urandom), 8'($urandom_range(255, 1)), 1'b0,
					ROLE_SHORT, 4'($urandom), rnd64()));
				5: send_read(c, $urandom_range(1023));
				6: send_release(c);
				default: send_word(mk_frame($urandom_range(15), 8'($urandom),
					($urandom_range(15) == 0) ? 8'd0 : 8'($urandom), 1'($urandom),
					2'($urandom), 4'($urandom), rnd64()));
			endcase
			if (i == count / 2) drain();
		end
	endtask

	initial begin
		errors = 0;
		mismatches = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		m_mask = 8'd0;
		for (int c = 0; c < NCH; c++) clear_ch(c);
		foreach (m_store[i]) begin
			m_store[i] = 8'd0;
			m_written[i] = 1'b0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 18;
		recv_idle_pct = 85;
		write_mask(8'hA5);
		test_random(180);
		send_idle_pct = 85;
		recv_idle_pct = 18;
		write_mask(8'h5A);
		test_random(120);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_mask(8'hFF);
		test_random(200);
		drain();
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

[filelist.f]
hdl/cmfr_pkg.sv
hdl/cmfr_ram.sv
hdl/cmfr_ctrl.sv
hdl/cmfr_dp.sv
hdl/can_multichannel_frame_reassembler.sv
hdl/cmfr_chk.sv
tb/sv/tb.sv
